// File: sv/sst_pkg.sv
// ============================================================================
// sst_pkg: shared types and constants of the sorted set table
// Field widths, operation and status codes, and the compare result type.
// ============================================================================
`default_nettype none

package sst_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 6;
    localparam int LIMIT_W  = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd8;

    typedef struct packed {
        logic less;
        logic equal;
    } cmp_t;

endpackage

`default_nettype wire

// File: sv/sst_entry_ram.sv
// ============================================================================
// sst_entry_ram: key storage of the sorted set table
// One write port and one read port; the read data is registered.
// ============================================================================
`default_nettype none

module sst_entry_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [sst_pkg::KEY_W-1:0] rd_data,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [sst_pkg::KEY_W-1:0] wr_data
);
    import sst_pkg::*;

    logic [KEY_W-1:0] mem_reg [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/sst_key_cmp.sv
// ============================================================================
// sst_key_cmp: signed key comparator
// Compares a stored entry with the operand key as signed Q16.16 values.
// ============================================================================
`default_nettype none

module sst_key_cmp (
    input  wire logic signed [sst_pkg::KEY_W-1:0] entry,
    input  wire logic signed [sst_pkg::KEY_W-1:0] key,
    output sst_pkg::cmp_t                         res
);
    import sst_pkg::*;

    always_comb
    begin
        res.less  = (entry < key);
        res.equal = (entry == key);
    end

endmodule

`default_nettype wire

// File: sv/sorted_set_table.sv
// ============================================================================
// sorted_set_table: ascending table of distinct signed Q16.16 keys
// Insert, remove, search and dump over a sorted, duplicate-free key store.
// ============================================================================
//
// A command is transferred at a rising edge with start high and busy low;
// opcode selects insert, remove, search or dump and key carries the operand.
// busy stays high until the command has finished, so commands run one at a
// time. Each result appears for exactly one cycle with done high; the
// receiver cannot stall, so every result is taken as it is shown.
//
// The keys live in a single-port-read, single-port-write memory. A small
// sequencer walks it with one shared signed comparator: a scan finds the
// first entry not less than the key, then entries are moved one place per
// cycle to open or close a gap. The registered memory read sets the pace.
// At worst an insert runs the scan to the position, a decision step, the
// moves and the final write; a remove ends with its last move, and a
// search ends at the decision. A dump gives one result per cycle, and an
// empty table gives a single empty result in the cycle after the transfer.
//
// Reset empties the table and sets the capacity limit to 32; the memory
// itself is not cleared, since only positions below the fill are read.
// The limit may be written through cfg_we/cfg_wdata while the block is idle.
// ============================================================================
`default_nettype none

module sorted_set_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [sst_pkg::OP_W-1:0]     opcode,
    input  wire logic signed [sst_pkg::KEY_W-1:0]    key,
    input  wire logic                                cfg_we,
    input  wire logic        [sst_pkg::LIMIT_W-1:0]  cfg_wdata,
    output logic                                     done,
    output logic             [sst_pkg::STATUS_W-1:0] status,
    output logic signed      [sst_pkg::KEY_W-1:0]    entry_value,
    output logic             [sst_pkg::COUNT_W-1:0]  entry_count,
    output logic                                     last
);
    import sst_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_SHIFT_UP = 3'd3;
    localparam logic [2:0] S_SHIFT_DN = 3'd4;
    localparam logic [2:0] S_PLACE    = 3'd5;
    localparam logic [2:0] S_DUMP     = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                hit_reg, hit_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]    value_reg, value_next;
    logic [COUNT_W-1:0]  ecount_reg, ecount_next;
    logic                last_reg, last_next;

    logic                rd_en;
    logic [CW-1:0]       rd_idx;
    logic                wr_en;
    logic [CW-1:0]       wr_idx;
    logic [KEY_W-1:0]    wr_data;
    logic [KEY_W-1:0]    rd_data;
    cmp_t                cmp;
    logic                full;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       idx_inc2;
    logic [CW-1:0]       idx_dec;

    sst_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_data)
    );

    sst_key_cmp u_cmp (
        .entry (rd_data),
        .key   (key_reg),
        .res   (cmp)
    );

    // The table is full once the fill reaches either the written limit or
    // the physical capacity, whichever is the smaller.
    assign full = (CMPW'(count_reg) >= CMPW'(limit_reg)) ||
                  (count_reg == CW'(CAPACITY));

    assign idx_inc  = CW'(idx_reg + 1'b1);
    assign idx_inc2 = CW'(idx_reg + 2'd2);
    assign idx_dec  = CW'(idx_reg - 1'b1);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = '0;
        last_next   = 1'b0;
        rd_en       = 1'b0;
        rd_idx      = '0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_data     = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode;
                    key_next = key;
                    idx_next = '0;
                    rd_en    = 1'b1;
                    rd_idx   = '0;
                    if (count_reg == '0)
                    begin
                        if (opcode == OP_DUMP)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            // Nothing to scan: the key would go at the front.
                            pos_next   = '0;
                            hit_next   = 1'b0;
                            state_next = S_DECIDE;
                        end
                    end
                    else if (opcode == OP_DUMP)
                    begin
                        state_next = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (cmp.less)
                begin
                    if (idx_inc == count_reg)
                    begin
                        pos_next   = count_reg;
                        hit_next   = 1'b0;
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_idx   = idx_inc;
                    end
                end
                else
                begin
                    pos_next   = idx_reg;
                    hit_next   = cmp.equal;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DUPLICATE;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (full)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_idx      = pos_reg;
                            count_next  = CW'(count_reg + 1'b1);
                            done_next   = 1'b1;
                            status_next = ST_INSERTED;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            rd_en      = 1'b1;
                            rd_idx     = CW'(count_reg - 1'b1);
                            state_next = S_SHIFT_UP;
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (CW'(pos_reg + 1'b1) == count_reg)
                        begin
                            count_next  = CW'(count_reg - 1'b1);
                            done_next   = 1'b1;
                            status_next = ST_REMOVED;
                            last_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            rd_en      = 1'b1;
                            rd_idx     = CW'(pos_reg + 1'b1);
                            state_next = S_SHIFT_DN;
                        end
                    end

                    default:
                    begin
                        done_next   = 1'b1;
                        status_next = hit_reg ? ST_FOUND : ST_ABSENT;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_SHIFT_UP:
            begin
                // idx_reg is the destination; the entry below it is on rd_data.
                wr_en   = 1'b1;
                wr_idx  = idx_reg;
                wr_data = rd_data;
                if (idx_dec == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_dec;
                    rd_en    = 1'b1;
                    rd_idx   = CW'(idx_reg - 2'd2);
                end
            end

            S_PLACE:
            begin
                wr_en       = 1'b1;
                wr_idx      = pos_reg;
                count_next  = CW'(count_reg + 1'b1);
                done_next   = 1'b1;
                status_next = ST_INSERTED;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_SHIFT_DN:
            begin
                // idx_reg is the destination; the entry above it is on rd_data.
                wr_en   = 1'b1;
                wr_idx  = idx_reg;
                wr_data = rd_data;
                if (idx_inc2 == count_reg)
                begin
                    count_next  = CW'(count_reg - 1'b1);
                    done_next   = 1'b1;
                    status_next = ST_REMOVED;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc2;
                end
            end

            S_DUMP:
            begin
                done_next   = 1'b1;
                status_next = ST_ENTRY;
                value_next  = rd_data;
                if (idx_inc == count_reg)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ecount_next = done_next ? COUNT_W'(count_next) : ecount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        ecount_reg <= ecount_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_value = value_reg;
    assign entry_count = ecount_reg;
    assign last        = last_reg;

    // The fill never grows beyond the physical capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    // A result that is not the last of its command belongs to a running dump.
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (busy && status == ST_ENTRY))
        else $error("non-final result outside a dump");

    // A transferred command either starts work or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command transferred but neither running nor answered");

    // Only dump entries carry a key value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_ENTRY) |-> (entry_value == '0))
        else $error("entry value set on a non-entry result");

endmodule

`default_nettype wire

// File: tb/sv/sorted_set_table_tb.sv
// ============================================================================
// sorted_set_table_tb: self-checking bench for the sorted set table
// Drives insert, remove, search and dump commands with random pacing and
// compares every result against a shadow copy of the table held in the bench.
// ============================================================================
`default_nettype none

module sorted_set_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CAPACITY      = 32;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 26;
    // The longest command (an insert at the front of a nearly full table, or
    // a full dump) stays well inside this limit, so this is a generous margin.
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = CAPACITY + 8;

    // ------------------------------------------------------------------------
    // Stimulus script. Besides commands it carries limit writes, which are
    // only issued once the table is idle, and drain points at which the
    // sender holds back until every owed result has been seen.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        STEP_COMMAND,
        STEP_LIMIT,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t                kind;
        logic [OP_W-1:0]           op;
        logic signed [KEY_W-1:0]   operand;
        logic [LIMIT_W-1:0]        limit;
        bit                        eager;
    } script_step_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [KEY_W-1:0]   value;
        logic [COUNT_W-1:0]        count;
        logic                      fin;
    } reply_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [OP_W-1:0]               opcode      = OP_SEARCH;
    logic signed [KEY_W-1:0]       key         = '0;
    logic                          cfg_we      = 1'b0;
    logic [LIMIT_W-1:0]            cfg_wdata   = '0;
    logic                          busy;
    logic                          done;
    logic [STATUS_W-1:0]           status;
    logic signed [KEY_W-1:0]       entry_value;
    logic [COUNT_W-1:0]            entry_count;
    logic                          last;

    script_step_t                  command_script [$];
    reply_t                        owed_replies [$];
    logic signed [KEY_W-1:0]       key_pool [$];

    // Shadow copy of the table: ascending distinct keys, the fill and the
    // capacity limit as the block should hold them after each transfer.
    logic signed [KEY_W-1:0]       shadow_keys [CAPACITY];
    int                            shadow_fill  = 0;
    logic [LIMIT_W-1:0]            shadow_limit = LIMIT_RESET;

    int                            fail_count   = 0;
    int                            quiet_cycles = 0;
    bit                            cmd_taken    = 1'b0;

    sorted_set_table #(
        .CAPACITY    (CAPACITY)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .status      (status),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .last        (last)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow table. Every result carries the fill as it stands after the
    // command, so the count is taken when the result is queued.
    // ------------------------------------------------------------------------
    function automatic void owe(input logic [STATUS_W-1:0] st,
                                input logic signed [KEY_W-1:0] value,
                                input bit fin);
        owed_replies.push_back('{st, value, COUNT_W'(shadow_fill), fin});
    endfunction

    function automatic void shadow_execute(input logic [OP_W-1:0] op,
                                           input logic signed [KEY_W-1:0] k);
        int slot;
        int room;
        bit hit;
        slot = 0;
        if (op == OP_DUMP)
        begin
            // An empty table still answers, with a single empty result.
            if (shadow_fill == 0)
                owe(ST_EMPTY, '0, 1'b1);
            for (int j = 0; j < shadow_fill; j++)
                owe(ST_ENTRY, shadow_keys[j], j + 1 == shadow_fill);
            return;
        end
        // First position whose key is not less than the operand, compared
        // as signed Q16.16 values.
        while (slot < shadow_fill && shadow_keys[slot] < k)
            slot++;
        hit  = (slot < shadow_fill) && (shadow_keys[slot] == k);
        // A limit above the physical size saturates at that size.
        room = (shadow_limit > CAPACITY) ? CAPACITY : int'(shadow_limit);
        case (op)
            OP_INSERT:
            begin
                // The duplicate test wins over the full test, and a limit
                // lowered below the fill drops nothing: it only refuses.
                if (hit)
                    owe(ST_DUPLICATE, '0, 1'b1);
                else if (shadow_fill >= room)
                    owe(ST_FULL, '0, 1'b1);
                else
                begin
                    for (int j = shadow_fill; j > slot; j--)
                        shadow_keys[j] = shadow_keys[j - 1];
                    shadow_keys[slot] = k;
                    shadow_fill++;
                    owe(ST_INSERTED, '0, 1'b1);
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (int j = slot; j + 1 < shadow_fill; j++)
                        shadow_keys[j] = shadow_keys[j + 1];
                    shadow_fill--;
                    owe(ST_REMOVED, '0, 1'b1);
                end
                else
                    owe(ST_NOT_FOUND, '0, 1'b1);
            end
            default:
                owe(hit ? ST_FOUND : ST_ABSENT, '0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(input string name,
                                        input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Script building.
    // ------------------------------------------------------------------------
    function automatic void add_command(input logic [OP_W-1:0] op,
                                        input logic signed [KEY_W-1:0] operand,
                                        input bit eager);
        command_script.push_back('{STEP_COMMAND, op, operand, '0, eager});
    endfunction

    function automatic void add_limit(input logic [LIMIT_W-1:0] value);
        command_script.push_back('{STEP_LIMIT, OP_SEARCH, '0, value, 1'b0});
    endfunction

    function automatic void add_drain();
        command_script.push_back('{STEP_DRAIN, OP_SEARCH, '0, '0, 1'b0});
    endfunction

    // One random phase: a new limit, some fresh keys for the shared pool,
    // then a run of commands. Keys mostly come from the pool so that
    // duplicates, hits and removals of held keys are common; the rest are
    // fully random. A drain point sits half way through.
    function automatic void add_random_phase(input logic [LIMIT_W-1:0] limit,
                                             input int count,
                                             input int ins_pct,
                                             input int rem_pct,
                                             input int fresh_keys,
                                             input bit eager);
        int                      roll;
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] operand;
        add_limit(limit);
        repeat (fresh_keys)
            key_pool.push_back($urandom);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                op = OP_INSERT;
            else if (roll < ins_pct + rem_pct)
                op = OP_REMOVE;
            else if (roll < 92)
                op = OP_SEARCH;
            else
                op = OP_DUMP;
            if ($urandom_range(0, 99) < 85)
                operand = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                operand = $urandom;
            add_command(op, operand, eager);
            if (n == count / 2)
                add_drain();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. Inputs change on the falling edge only. A command stays
    // on the bus with start high until the monitor reports its transfer; the
    // next one may follow straight away, so start is only ever assigned once
    // per edge. Limit writes and drain points wait for an idle block.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        script_step_t head;
        logic         next_start;
        logic         next_we;
        next_start = start;
        next_we    = 1'b0;
        if (rst_n)
        begin
            if (start && cmd_taken)
            begin
                command_script.delete(0);
                next_start = 1'b0;
            end
            if (!next_start && command_script.size() > 0)
            begin
                head = command_script[0];
                case (head.kind)
                    STEP_COMMAND:
                    begin
                        // Random gaps, except in the eager stretch.
                        if (head.eager || $urandom_range(0, 99) >= IDLE_PCT)
                        begin
                            next_start = 1'b1;
                            opcode     <= head.op;
                            key        <= head.operand;
                        end
                    end
                    STEP_LIMIT:
                    begin
                        if (owed_replies.size() == 0 && !busy)
                        begin
                            next_we   = 1'b1;
                            cfg_wdata <= head.limit;
                            command_script.delete(0);
                        end
                    end
                    default:
                    begin
                        if (owed_replies.size() == 0 && !busy)
                            command_script.delete(0);
                    end
                endcase
            end
        end
        start  <= next_start;
        cfg_we <= next_we;
    end

    // ------------------------------------------------------------------------
    // Monitor. Results are checked before a transfer on the same edge is
    // applied to the shadow table, since a new command's results can never
    // appear on the edge that transfers it. The watchdog counts edges at
    // which nothing at all moves.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t seen;
        reply_t want;
        bit     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                seen  = '{status, entry_value, entry_count, last};
                if (owed_replies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, seen);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("entry_value", want.value, seen.value);
                    check_field("entry_count", want.count, seen.count);
                    check_field("last", want.fin, seen.fin);
                end
            end
            cmd_taken = start && !busy;
            if (cmd_taken)
            begin
                moved = 1'b1;
                shadow_execute(opcode, key);
            end
            if (cfg_we)
            begin
                moved        = 1'b1;
                shadow_limit = cfg_wdata;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[sorted_set_table] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Script, reset and verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        // Directed opening: empty table, the key extremes, a duplicate,
        // removals at both ends and in the middle, then a limit lowered
        // below the fill so that inserts are refused while a duplicate is
        // still reported as such, and finally a zero limit.
        add_command(OP_DUMP,   '0,            1'b0);
        add_command(OP_SEARCH, 32'h0000_0000, 1'b0);
        add_command(OP_REMOVE, 32'h0000_0000, 1'b0);
        add_command(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
        add_command(OP_INSERT, 32'h8000_0000, 1'b0);
        add_command(OP_INSERT, 32'h0000_0000, 1'b0);
        add_command(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        add_command(OP_INSERT, 32'h0001_0000, 1'b0);
        add_command(OP_INSERT, 32'h0000_0000, 1'b0);
        add_command(OP_SEARCH, 32'h8000_0000, 1'b0);
        add_command(OP_SEARCH, 32'h1234_5678, 1'b0);
        add_command(OP_DUMP,   '0,            1'b0);
        add_command(OP_REMOVE, 32'h8000_0000, 1'b0);
        add_command(OP_REMOVE, 32'h0000_0000, 1'b0);
        add_command(OP_REMOVE, 32'h7FFF_FFFF, 1'b0);
        add_command(OP_REMOVE, 32'h7FFF_FFFF, 1'b0);
        add_limit(6'd1);
        add_command(OP_INSERT, 32'h0005_0000, 1'b0);
        add_command(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        add_command(OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
        add_command(OP_INSERT, 32'h0007_0000, 1'b0);
        add_command(OP_DUMP,   '0,            1'b0);
        add_limit(6'd0);
        add_command(OP_INSERT, 32'h0002_0000, 1'b0);
        add_command(OP_SEARCH, 32'h0001_0000, 1'b0);

        // Random phases. The first fills the table up to its physical size
        // with the limit at its top value; the second lowers the limit well
        // below the fill and drains the table with no gaps at all.
        key_pool.push_back(32'h7FFF_FFFF);
        key_pool.push_back(32'h8000_0000);
        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFF);
        add_random_phase(6'd63, 90, 65, 10, 40, 1'b0);
        add_random_phase(6'd5,  60, 25, 50, 8,  1'b1);
        add_random_phase(6'd32, 80, 45, 30, 8,  1'b0);
        add_random_phase(6'd0,  30, 40, 30, 4,  1'b0);
        add_random_phase(6'd1,  40, 45, 30, 4,  1'b0);
        add_random_phase(LIMIT_W'($urandom_range(2, 31)), 80, 45, 30, 8, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (command_script.size() > 0 || start)
            @(posedge clk);
        while (owed_replies.size() > 0)
            @(posedge clk);
        // Anything arriving now is a stray result and is caught above.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[sorted_set_table] OK");
        else
            $display("[sorted_set_table] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
